// ----- rtl/core/stt_pkg.sv -----
// Shared types and constants for the session token table with aging.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package stt_pkg;

    // Table geometry.
    localparam int unsigned ENTRIES = 64;
    localparam int unsigned IDX_W   = $clog2(ENTRIES);
    localparam int unsigned CNT_W   = 7;
    localparam logic [CNT_W-1:0] CNT_MAX  = '1;
    localparam logic [IDX_W:0]   SCAN_END = (IDX_W + 1)'(ENTRIES);

    // Operation codes carried in the kind field.
    localparam logic [1:0] KIND_PUT    = 2'd0;
    localparam logic [1:0] KIND_VERIFY = 2'd1;
    localparam logic [1:0] KIND_TICK   = 2'd2;

    // Result status codes.
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_REFRESHED = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_VERIFY_OK = 3'd3;
    localparam logic [2:0] ST_VERIFY_NG = 3'd4;
    localparam logic [2:0] ST_SWEPT     = 3'd5;
    localparam logic [2:0] ST_SKIPPED   = 3'd6;

    // Configuration port.
    localparam int unsigned ADDR_W       = 3;
    localparam logic        REG_TIMEOUT  = 1'b0;
    localparam logic        REG_INTERVAL = 1'b1;
    localparam logic [31:0] TIMEOUT_RST  = 32'd10000;
    localparam logic [31:0] INTERVAL_RST = 32'd1000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] account_id;
        logic [63:0] session_token;
        logic [31:0] now_time;
    } item_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [CNT_W-1:0] removed_count;
    } result_t;

    typedef struct packed {
        logic [31:0] account;
        logic [63:0] token;
        logic [31:0] stamp;
    } entry_t;

    // Per-entry verdict of the shared compare unit.
    typedef struct packed {
        logic match;
        logic token_eq;
        logic aged;
    } eval_t;

endpackage

`default_nettype wire

// ----- rtl/core/stt_table.sv -----
// Entry storage: a single-port-write, registered-read memory for the entry
// payload and a flip-flop valid vector. Depends on stt_pkg.
`default_nettype none

module stt_table
    import stt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             rd_en,
    input  wire logic [IDX_W-1:0] rd_addr,
    output entry_t                rd_data,
    input  wire logic             wr_en,
    input  wire logic [IDX_W-1:0] wr_addr,
    input  wire entry_t           wr_data,
    input  wire logic             set_en,
    input  wire logic [IDX_W-1:0] set_addr,
    input  wire logic             clr_en,
    input  wire logic [IDX_W-1:0] clr_addr,
    output logic [ENTRIES-1:0]    valid
);

    entry_t               mem [ENTRIES];
    entry_t               rd_data_reg;
    logic [ENTRIES-1:0]   valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Valid bits clear at once on reset, so the payload memory never needs it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (set_en)
            begin
                valid_reg[set_addr] <= 1'b1;
            end
            if (clr_en)
            begin
                valid_reg[clr_addr] <= 1'b0;
            end
        end
    end

    assign rd_data = rd_data_reg;
    assign valid   = valid_reg;

endmodule

`default_nettype wire

// ----- rtl/core/stt_cmp.sv -----
// Shared compare unit: judges one table entry against the current item.
// Depends on stt_pkg.
`default_nettype none

module stt_cmp
    import stt_pkg::*;
(
    input  wire entry_t        ent,
    input  wire logic          ent_valid,
    input  wire item_t         itm,
    input  wire logic [31:0]   timeout,
    output eval_t              ev
);

    logic [31:0] age;

    // Age is taken modulo 2^32, so a wrapped clock still ages correctly.
    assign age         = itm.now_time - ent.stamp;
    assign ev.match    = ent_valid && (ent.account == itm.account_id);
    assign ev.token_eq = (ent.token == itm.session_token);
    assign ev.aged     = ent_valid && (age >= timeout);

endmodule

`default_nettype wire

// ----- rtl/core/stt_seq.sv -----
// Sequencer: accepts a transaction, walks the table one entry per cycle
// through the shared compare unit and issues the result. Depends on stt_pkg.
`default_nettype none

module stt_seq
    import stt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire item_t            item,
    output logic                  busy,
    output logic                  done,
    output result_t               result,
    input  wire logic [31:0]      interval,
    output item_t                 cur_item,
    input  wire eval_t            ev,
    input  wire logic [ENTRIES-1:0] valid,
    output logic                  chk_valid,
    output logic                  rd_en,
    output logic [IDX_W-1:0]      rd_addr,
    output logic                  wr_en,
    output logic [IDX_W-1:0]      wr_addr,
    output logic                  set_en,
    output logic [IDX_W-1:0]      set_addr,
    output logic                  clr_en,
    output logic [IDX_W-1:0]      clr_addr
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t            state_reg,    state_next;
    item_t             item_reg,     item_next;
    logic [IDX_W:0]    addr_reg,     addr_next;
    logic              chk_vld_reg,  chk_vld_next;
    logic [IDX_W-1:0]  chk_idx_reg,  chk_idx_next;
    logic              hit_reg,      hit_next;
    logic [IDX_W-1:0]  hit_idx_reg,  hit_idx_next;
    logic              tok_ok_reg,   tok_ok_next;
    logic              free_reg,     free_next;
    logic [IDX_W-1:0]  free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]  cnt_reg,      cnt_next;
    logic [31:0]       sweep_reg,    sweep_next;
    logic              done_reg,     done_next;
    result_t           result_reg,   result_next;
    logic [31:0]       since_sweep;
    logic              vld_bit;

    assign since_sweep = item.now_time - sweep_reg;
    assign vld_bit     = valid[chk_idx_reg];

    always_comb
    begin
        state_next    = state_reg;
        item_next     = item_reg;
        addr_next     = addr_reg;
        chk_vld_next  = 1'b0;
        chk_idx_next  = addr_reg[IDX_W-1:0];
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        tok_ok_next   = tok_ok_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        cnt_next      = cnt_reg;
        sweep_next    = sweep_reg;
        done_next     = 1'b0;
        result_next   = result_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    addr_next = '0;
                    hit_next  = 1'b0;
                    tok_ok_next = 1'b0;
                    free_next = 1'b0;
                    cnt_next  = '0;
                    case (item.kind) inside
                        KIND_PUT, KIND_VERIFY:
                        begin
                            state_next = S_SCAN;
                        end
                        KIND_TICK:
                        begin
                            // Sweep only once the sweep time has been reached.
                            if (!since_sweep[31])
                            begin
                                sweep_next = item.now_time + interval;
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                done_next   = 1'b1;
                                result_next = '{status: ST_SKIPPED, removed_count: '0};
                            end
                        end
                        default:
                        begin
                            done_next   = 1'b1;
                            result_next = '{status: ST_SKIPPED, removed_count: '0};
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (addr_reg != SCAN_END)
                begin
                    addr_next    = addr_reg + 1'b1;
                    chk_vld_next = 1'b1;
                end
                else
                begin
                    state_next = S_FINISH;
                end
                if (chk_vld_reg)
                begin
                    case (item_reg.kind)
                        KIND_PUT:
                        begin
                            if (ev.match && !hit_reg)
                            begin
                                hit_next     = 1'b1;
                                hit_idx_next = chk_idx_reg;
                            end
                            if (!vld_bit && !free_reg)
                            begin
                                free_next     = 1'b1;
                                free_idx_next = chk_idx_reg;
                            end
                        end
                        KIND_VERIFY:
                        begin
                            if (ev.match && !hit_reg)
                            begin
                                hit_next     = 1'b1;
                                hit_idx_next = chk_idx_reg;
                                tok_ok_next  = ev.token_eq;
                            end
                        end
                        KIND_TICK:
                        begin
                            if (ev.aged && (cnt_reg != CNT_MAX))
                            begin
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            S_FINISH:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                case (item_reg.kind)
                    KIND_PUT:
                    begin
                        if (hit_reg)
                        begin
                            result_next = '{status: ST_REFRESHED, removed_count: '0};
                        end
                        else if (free_reg)
                        begin
                            result_next = '{status: ST_INSERTED, removed_count: '0};
                        end
                        else
                        begin
                            result_next = '{status: ST_FULL, removed_count: '0};
                        end
                    end
                    KIND_VERIFY:
                    begin
                        if (hit_reg && tok_ok_reg)
                        begin
                            result_next = '{status: ST_VERIFY_OK,
                                            removed_count: CNT_W'(1)};
                        end
                        else
                        begin
                            result_next = '{status: ST_VERIFY_NG, removed_count: '0};
                        end
                    end
                    KIND_TICK:
                    begin
                        result_next = '{status: ST_SWEPT, removed_count: cnt_reg};
                    end
                    default:
                    begin
                        result_next = '{status: ST_SKIPPED, removed_count: '0};
                    end
                endcase
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            item_reg     <= '0;
            addr_reg     <= '0;
            chk_vld_reg  <= 1'b0;
            chk_idx_reg  <= '0;
            hit_reg      <= 1'b0;
            hit_idx_reg  <= '0;
            tok_ok_reg   <= 1'b0;
            free_reg     <= 1'b0;
            free_idx_reg <= '0;
            cnt_reg      <= '0;
            sweep_reg    <= '0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            item_reg     <= item_next;
            addr_reg     <= addr_next;
            chk_vld_reg  <= chk_vld_next;
            chk_idx_reg  <= chk_idx_next;
            hit_reg      <= hit_next;
            hit_idx_reg  <= hit_idx_next;
            tok_ok_reg   <= tok_ok_next;
            free_reg     <= free_next;
            free_idx_reg <= free_idx_next;
            cnt_reg      <= cnt_next;
            sweep_reg    <= sweep_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
        end
    end

    // Table control. Reads are issued while scanning; the verdict comes back
    // in the next cycle together with chk_vld_reg.
    assign rd_en    = (state_reg == S_SCAN) && (addr_reg != SCAN_END);
    assign rd_addr  = addr_reg[IDX_W-1:0];

    assign wr_en    = (state_reg == S_FINISH) && (item_reg.kind == KIND_PUT)
                      && (hit_reg || free_reg);
    assign wr_addr  = hit_reg ? hit_idx_reg : free_idx_reg;
    assign set_en   = (state_reg == S_FINISH) && (item_reg.kind == KIND_PUT)
                      && !hit_reg && free_reg;
    assign set_addr = free_idx_reg;

    always_comb
    begin
        if (state_reg == S_FINISH)
        begin
            clr_en   = (item_reg.kind == KIND_VERIFY) && hit_reg && tok_ok_reg;
            clr_addr = hit_idx_reg;
        end
        else
        begin
            clr_en   = (state_reg == S_SCAN) && chk_vld_reg
                       && (item_reg.kind == KIND_TICK) && ev.aged;
            clr_addr = chk_idx_reg;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cur_item  = item_reg;
    assign chk_valid = vld_bit;

endmodule

`default_nettype wire

// ----- rtl/core/session_token_table_with_aging.sv -----
// Top level of the session token table with aging: configuration registers,
// the sequencer, the shared compare unit and the entry table. Depends on stt_pkg.
`default_nettype none

// A transaction is accepted at a rising edge where start is high and busy is
// low. A put, a verify, or a tick that reaches the sweep time walks all 64
// table entries through one shared compare unit, one entry per cycle behind
// the registered memory read; the result appears in the first cycle with busy
// low again, in which the next transaction may already be accepted. A tick
// that does not reach the sweep time, and an unused kind code, answer in the
// cycle after acceptance without going busy. The result is shown for one
// cycle with done high; the receiver cannot hold it off, so it must capture
// every strobe. A put for a new account takes the lowest free entry; with no
// free entry it reports table full and changes nothing. Timeout and sweep
// interval must be written over the APB port while the block is idle; the
// block itself does not enforce this. There is no clearing pass after reset,
// since only the valid bits are reset and they are cleared at once.

module session_token_table_with_aging
    import stt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire item_t             item,
    output logic                   done,
    output result_t                result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    logic [31:0]        timeout_reg;
    logic [31:0]        interval_reg;
    logic               cfg_wr;
    logic               reg_sel;

    item_t              cur_item;
    eval_t              ev;
    entry_t             rd_data;
    entry_t             wr_data;
    logic [ENTRIES-1:0] valid;
    logic               chk_valid;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               set_en;
    logic [IDX_W-1:0]   set_addr;
    logic               clr_en;
    logic [IDX_W-1:0]   clr_addr;

    // Register i sits at byte address 4*i, so the word index is the top bit.
    assign reg_sel = paddr[ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= TIMEOUT_RST;
            interval_reg <= INTERVAL_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_sel)
                REG_TIMEOUT:  timeout_reg  <= pwdata;
                REG_INTERVAL: interval_reg <= pwdata;
                default:      timeout_reg  <= timeout_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_TIMEOUT:  prdata = timeout_reg;
            REG_INTERVAL: prdata = interval_reg;
            default:      prdata = '0;
        endcase
    end

    // A put writes the whole entry when it stores; on a refresh the account is the same.
    assign wr_data = '{account: cur_item.account_id,
                       token:   cur_item.session_token,
                       stamp:   cur_item.now_time};

    stt_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .interval  (interval_reg),
        .cur_item  (cur_item),
        .ev        (ev),
        .valid     (valid),
        .chk_valid (chk_valid),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .set_en    (set_en),
        .set_addr  (set_addr),
        .clr_en    (clr_en),
        .clr_addr  (clr_addr)
    );

    stt_cmp u_cmp (
        .ent       (rd_data),
        .ent_valid (chk_valid),
        .itm       (cur_item),
        .timeout   (timeout_reg),
        .ev        (ev)
    );

    stt_table u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .set_en   (set_en),
        .set_addr (set_addr),
        .clr_en   (clr_en),
        .clr_addr (clr_addr),
        .valid    (valid)
    );

endmodule

`default_nettype wire

// ----- rtl/core/stt_checker.sv -----
// Port-level checker for the session token table and the bind that attaches
// it to the top level. Depends on stt_pkg.
`default_nettype none

module stt_checker
    import stt_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              start,
    input wire logic              busy,
    input wire item_t             item,
    input wire logic              done,
    input wire result_t           result
);

    // A put always walks the table.
    a_put_scans: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.kind == KIND_PUT) |=> busy)
        else $error("put transaction did not start a table walk");

    // A result is never shown while a transaction is still at work.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // Every walk ends in a result.
    a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("walk ended without a result");

    // A successful verify removes exactly one entry.
    a_verify_one: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == ST_VERIFY_OK) |-> (result.removed_count == CNT_W'(1)))
        else $error("verify ok with wrong removed count");

    // Only a sweep or a successful verify removes anything.
    a_no_removal: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != ST_SWEPT) && (result.status != ST_VERIFY_OK)
        |-> (result.removed_count == '0))
        else $error("removal reported for a non-removing status");

endmodule

bind session_token_table_with_aging stt_checker u_stt_checker (.*);

`default_nettype wire

// ----- sim/session_token_table_with_aging_test.sv -----
// Self-checking testbench for the session token table with aging.
// Drives put, verify and tick transactions and checks every result against
// an internal model; depends on stt_pkg and session_token_table_with_aging.
`timescale 1ns / 100ps

module session_token_table_with_aging_test;
    import stt_pkg::*;

    localparam int CLK_PERIOD = 10;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 100;
    localparam int POOL_SIZE = 80;

    // Kind code that the block does not define; it must answer sweep skipped.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    // Register byte addresses: register i sits at 4*i.
    localparam logic [ADDR_W-1:0] ADDR_TIMEOUT  = {REG_TIMEOUT, 2'b00};
    localparam logic [ADDR_W-1:0] ADDR_INTERVAL = {REG_INTERVAL, 2'b00};

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    item_t             item = '0;
    logic              done;
    result_t           result;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0]       pwdata = '0;
    logic [31:0]       prdata;
    logic              pready;

    session_token_table_with_aging dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .item    (item),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Transactions waiting to be offered, and outcomes waiting for their strobe.
    item_t   pending_items[$];
    result_t awaited_outcomes[$];

    logic item_taken = 1'b0;
    bit   steady_sender = 1'b0;
    int   failures = 0;
    int   stall_cycles = 0;

    // Model of the session table. Only the valid bits matter at reset, since
    // account, token and stamp are read only behind a set valid bit.
    bit          slot_used [ENTRIES];
    logic [31:0] slot_account [ENTRIES];
    logic [63:0] slot_token [ENTRIES];
    logic [31:0] slot_stamp [ENTRIES];
    logic [31:0] next_sweep = '0;
    logic [31:0] age_limit = TIMEOUT_RST;
    logic [31:0] sweep_step = INTERVAL_RST;

    // Stimulus-side memory of the last token put per account, so that a good
    // share of verify transactions carry the right token.
    logic [63:0] issued_token [logic [31:0]];
    logic [31:0] clock_now = '0;

    function automatic int find_session(input logic [31:0] acct);
        for (int i = 0; i < ENTRIES; i++)
            if (slot_used[i] && slot_account[i] == acct)
                return i;
        return -1;
    endfunction

    // Applies one transaction to the model and returns the result it must give.
    function automatic result_t session_outcome(input item_t op);
        result_t     r;
        int          hit;
        logic [31:0] span;
        r.status = ST_SKIPPED;
        r.removed_count = '0;
        case (op.kind)
            KIND_PUT:
            begin
                hit = find_session(op.account_id);
                if (hit >= 0)
                begin
                    slot_token[hit] = op.session_token;
                    slot_stamp[hit] = op.now_time;
                    r.status = ST_REFRESHED;
                end
                else
                begin
                    // A new account takes the lowest free slot, or is dropped.
                    r.status = ST_FULL;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        if (!slot_used[i])
                        begin
                            slot_used[i] = 1'b1;
                            slot_account[i] = op.account_id;
                            slot_token[i] = op.session_token;
                            slot_stamp[i] = op.now_time;
                            r.status = ST_INSERTED;
                            break;
                        end
                    end
                end
            end
            KIND_VERIFY:
            begin
                hit = find_session(op.account_id);
                r.status = ST_VERIFY_NG;
                if (hit >= 0 && slot_token[hit] == op.session_token)
                begin
                    slot_used[hit] = 1'b0;
                    r.status = ST_VERIFY_OK;
                    r.removed_count = CNT_W'(1);
                end
            end
            KIND_TICK:
            begin
                // The sweep time is reached when the wrapped distance has its
                // top bit clear.
                span = op.now_time - next_sweep;
                if (!span[31])
                begin
                    next_sweep = op.now_time + sweep_step;
                    for (int i = 0; i < ENTRIES; i++)
                    begin
                        span = op.now_time - slot_stamp[i];
                        if (slot_used[i] && span >= age_limit)
                        begin
                            slot_used[i] = 1'b0;
                            if (r.removed_count != CNT_MAX)
                                r.removed_count = r.removed_count + 1'b1;
                        end
                    end
                    r.status = ST_SWEPT;
                end
            end
            default:
                r.status = ST_SKIPPED;
        endcase
        return r;
    endfunction

    task automatic log_failure(input string msg);
        failures++;
        if (failures <= 10)
            $display("[%0t] %s", $time, msg);
    endtask

    // Driver: a transaction is offered from the falling edge and stays on the
    // bus until a rising edge sees start high with busy low. Roughly one
    // offer in ten is held back, except while the sender runs steady.
    always @(negedge clk)
    begin
        if (rst_n && (!start || item_taken))
        begin
            if (pending_items.size() != 0 &&
                (steady_sender || $urandom_range(99) >= 10))
            begin
                start <= 1'b1;
                item <= pending_items.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // Monitor: predicts each accepted transaction and checks each strobed
    // result against the oldest outstanding prediction. A result may come
    // at the same edge as the next acceptance; the queue keeps them in order.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            item_taken <= start && !busy;
            if (start && !busy)
                awaited_outcomes.push_back(session_outcome(item));
            if (done)
            begin
                if (awaited_outcomes.size() == 0)
                    log_failure($sformatf("unexpected result: status %0d removed %0d",
                                          result.status, result.removed_count));
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (result.status !== want.status ||
                        result.removed_count !== want.removed_count)
                        log_failure($sformatf("status exp %0d got %0d, removed exp %0d got %0d",
                                              want.status, result.status,
                                              want.removed_count, result.removed_count));
                end
            end
        end
    end

    // Watchdog: the run is stuck if nothing moves in either direction for
    // far longer than one scan takes from acceptance to result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || done)
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("[%0t] watchdog expired, %0d outcomes outstanding",
                         $time, awaited_outcomes.size());
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        // The block is idle, so the model can follow the write at once.
        if (addr == ADDR_TIMEOUT)
            age_limit = data;
        else
            sweep_step = data;
    endtask

    task automatic add_op(input logic [1:0] kind, input logic [31:0] acct,
                          input logic [63:0] token, input logic [31:0] stamp);
        item_t op;
        op.kind = kind;
        op.account_id = acct;
        op.session_token = token;
        op.now_time = stamp;
        pending_items.push_back(op);
    endtask

    // Holds the sender until every queued transaction has gone out and every
    // result has come back.
    task automatic wait_quiet();
        @(negedge clk);
        while (pending_items.size() != 0 || start || busy || done ||
               awaited_outcomes.size() != 0)
            @(negedge clk);
    endtask

    // One random phase: mostly puts and verifies on a small pool of accounts
    // so that refresh, verify success, expiry and a full table all occur,
    // with some ticks, some foreign accounts and a few unused kind codes.
    task automatic random_phase(input int count, input logic [31:0] tmo,
                                input logic [31:0] ivl, input bit steady);
        logic [31:0] acct_pool [POOL_SIZE];
        logic [31:0] acct;
        logic [63:0] token;
        int          pick;
        apb_write(ADDR_TIMEOUT, tmo);
        apb_write(ADDR_INTERVAL, ivl);
        steady_sender = steady;
        foreach (acct_pool[i])
            acct_pool[i] = $urandom;
        clock_now = $urandom;
        for (int n = 0; n < count; n++)
        begin
            if (n == count / 2)
                wait_quiet();
            if ($urandom_range(99) < 2)
                clock_now = clock_now + $urandom;
            else
                clock_now = clock_now + $urandom_range(40);
            if ($urandom_range(99) < 95)
                acct = acct_pool[$urandom_range(POOL_SIZE - 1)];
            else
                acct = $urandom;
            token = {$urandom, $urandom};
            pick = $urandom_range(99);
            if (pick < 40)
            begin
                issued_token[acct] = token;
                add_op(KIND_PUT, acct, token, clock_now);
            end
            else if (pick < 75)
            begin
                if (issued_token.exists(acct) && $urandom_range(99) < 70)
                    token = issued_token[acct];
                add_op(KIND_VERIFY, acct, token, clock_now);
            end
            else if (pick < 95)
                add_op(KIND_TICK, acct, token, clock_now);
            else
                add_op(KIND_UNUSED, acct, token, clock_now);
        end
        wait_quiet();
        steady_sender = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset register values. The first tick
        // meets a sweep time of zero and arms the next sweep at 1000.
        add_op(KIND_TICK, 32'd0, 64'd0, 32'd0);
        add_op(KIND_TICK, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd500);
        add_op(KIND_UNUSED, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        add_op(KIND_PUT, 32'd0, 64'd0, 32'd100);
        add_op(KIND_PUT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd200);
        // Refresh of an account that is present.
        add_op(KIND_PUT, 32'd0, 64'h1234, 32'd300);
        // Verify misses: a stale token, then an account never seen.
        add_op(KIND_VERIFY, 32'd0, 64'd0, 32'd310);
        add_op(KIND_VERIFY, 32'h5555, 64'h1234, 32'd320);
        add_op(KIND_VERIFY, 32'd0, 64'h1234, 32'd330);
        // The freed lowest slot is taken again.
        add_op(KIND_PUT, 32'd7, 64'h8000_0000_0000_0001, 32'd400);
        add_op(KIND_TICK, 32'd0, 64'd0, 32'd1000);
        add_op(KIND_TICK, 32'd0, 64'd0, 32'd20000);
        // Far enough behind the sweep time in wrapped terms to be skipped.
        add_op(KIND_TICK, 32'd0, 64'd0, 32'hFFFF_FF00);
        wait_quiet();

        // Zero timeout expires everything at a sweep; zero interval lets a
        // repeated tick at the same time sweep again.
        apb_write(ADDR_TIMEOUT, 32'd0);
        apb_write(ADDR_INTERVAL, 32'd0);
        add_op(KIND_PUT, 32'h1111, 64'hA5A5, 32'd21000);
        add_op(KIND_PUT, 32'h2222, 64'h5A5A, 32'd21005);
        add_op(KIND_TICK, 32'd0, 64'd0, 32'd21010);
        add_op(KIND_PUT, 32'h3333, 64'h0F0F, 32'd21010);
        add_op(KIND_TICK, 32'd0, 64'd0, 32'd21010);
        wait_quiet();

        // Random part under several settings, the extremes among them.
        random_phase(300, 32'd300, 32'd100, 1'b1);
        random_phase(300, 32'hFFFF_FFFF, 32'd1, 1'b0);
        random_phase(300, 32'd1, 32'hFFFF_FFFF, 1'b0);
        random_phase(300, $urandom_range(5000, 50), $urandom_range(500, 1), 1'b0);

        // Let any stray strobe show up before the verdict.
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_outcomes.size() != 0)
            log_failure($sformatf("%0d outcomes never arrived", awaited_outcomes.size()));
        if (failures == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
